// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CFFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define CFFA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/cffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_pkg
// Shared widths, codes and controller/datapath interface types for the
// circular first-fit allocator.
// ----------------------------------------------------------------------------
package cffa_pkg;

    localparam int ARENA_WORDS_DEF    = 1024;
    localparam int BYTES_PER_WORD_DEF = 6;

    localparam int SIZE_W    = 13;
    localparam int ADDR_W    = 10;
    localparam int STATUS_W  = 2;
    localparam int NEED_W    = SIZE_W + 1;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_IGNORED  = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic start;
        logic free_rd;
        logic free_ign;
        logic free_wr;
        logic chk_p;
        logic merge;
        logic split;
        logic mark;
        logic adv;
        logic fail;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic free_bad;
        logic p_busy;
        logic q_stop;
        logic fit;
        logic split_need;
        logic adv_stop;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/cffa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_dp
// Datapath: header RAM, walk pointers, loop counters, size-to-words
// conversion and the result register.
// ----------------------------------------------------------------------------
module cffa_dp
    import cffa_pkg::*;
#(
    parameter int ARENA_WORDS    = ARENA_WORDS_DEF,
    parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output stat_t               st,
    input  logic                s_op,
    input  logic [SIZE_W-1:0]   s_size,
    input  logic [ADDR_W-1:0]   s_addr,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [STATUS_W-1:0] m_status,
    output logic [ADDR_W-1:0]   m_payload
);

    localparam int IDX_W   = $clog2(ARENA_WORDS);
    localparam int WORD_W  = IDX_W + 1;
    localparam int GUARD_W = IDX_W + 3;
    localparam int G2_W    = IDX_W + 1;
    localparam int CMP_W   = IDX_W + NEED_W + 1;

    localparam logic [IDX_W-1:0]   TOP        = IDX_W'(ARENA_WORDS - 1);
    localparam logic [GUARD_W-1:0] GUARD_LAST = GUARD_W'(4 * ARENA_WORDS - 1);
    localparam logic [G2_W-1:0]    G2_LIM     = G2_W'(ARENA_WORDS);

    // ceil(bytes / BYTES_PER_WORD) plus one header word, by reciprocal multiply, exact over the input range
    localparam int RECIP_SH = NEED_W + $clog2(BYTES_PER_WORD) + 1;
    localparam int PROD_W   = NEED_W + RECIP_SH + 1;
    localparam logic [RECIP_SH:0] RECIP = (RECIP_SH + 1)'(
        ((64'd1 << RECIP_SH) + 64'(BYTES_PER_WORD) - 64'd1) / 64'(BYTES_PER_WORD));

    logic [WORD_W-1:0] mem [ARENA_WORDS];

    logic [WORD_W-1:0]   rdata_reg;
    logic                op_reg, op_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]    plink_reg, plink_next;
    logic [IDX_W-1:0]    sp_reg, sp_next;
    logic [1:0]          wraps_reg, wraps_next;
    logic [GUARD_W-1:0]  guard_reg, guard_next;
    logic [G2_W-1:0]     g2_reg, g2_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ADDR_W-1:0]   m_payload_reg, m_payload_next;

    logic                rd_busy;
    logic [IDX_W-1:0]    rd_link;
    logic [NEED_W-1:0]   byte_sum;
    logic [PROD_W-1:0]   prod;
    logic [NEED_W-1:0]   need_calc;
    logic [CMP_W-1:0]    p_w, plink_w, need_w, nb_w, pp1_w, addr_w, fa_w;
    logic [IDX_W-1:0]    nb;
    logic [IDX_W-1:0]    free_idx;
    logic                wrap;
    logic [1:0]          wraps_adv;
    logic [WORD_W-1:0]   init_word;
    logic                out_free;

    logic                we;
    logic [IDX_W-1:0]    waddr, raddr;
    logic [WORD_W-1:0]   wdata;

    assign rd_busy = rdata_reg[IDX_W];
    assign rd_link = rdata_reg[IDX_W-1:0];

    assign byte_sum  = NEED_W'(size_reg) + NEED_W'(BYTES_PER_WORD - 1);
    assign prod      = PROD_W'(byte_sum) * PROD_W'(RECIP);
    assign need_calc = prod[RECIP_SH +: NEED_W] + NEED_W'(1);

    assign p_w      = CMP_W'(p_reg);
    assign plink_w  = CMP_W'(plink_reg);
    assign need_w   = CMP_W'(need_reg);
    assign nb_w     = p_w + need_w;
    assign nb       = nb_w[IDX_W-1:0];
    assign pp1_w    = p_w + CMP_W'(1);
    assign addr_w   = CMP_W'(addr_reg);
    assign fa_w     = addr_w - CMP_W'(1);
    assign free_idx = fa_w[IDX_W-1:0];

    assign wrap      = (plink_reg <= p_reg);
    assign wraps_adv = wraps_reg + {1'b0, wrap};

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (clr_reg == '0) begin
            init_word = {1'b0, TOP};
        end else if (clr_reg == TOP) begin
            init_word = {1'b1, {IDX_W{1'b0}}};
        end else begin
            init_word = '0;
        end
    end

    always_comb begin
        st.clr_last   = (clr_reg == TOP);
        st.is_free    = (op_t'(op_reg) == OP_FREE);
        st.free_bad   = (addr_reg == '0) || (addr_w >= CMP_W'(TOP));
        st.p_busy     = rd_busy;
        st.q_stop     = rd_busy || (g2_reg >= G2_LIM);
        st.fit        = (plink_w > p_w) && ((plink_w - p_w) >= need_w);
        st.split_need = (plink_w > nb_w);
        st.adv_stop   = (wraps_adv >= 2'd2) || (guard_reg == GUARD_LAST);
        st.out_free   = out_free;
    end

    // header RAM port selection
    always_comb begin
        we    = 1'b0;
        waddr = p_reg;
        wdata = '0;
        raddr = p_reg;
        if (cmd.clr_wr) begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = init_word;
        end
        if (cmd.start) begin
            raddr = sp_reg;
        end
        if (cmd.chk_p) begin
            raddr = rd_link;
        end
        if (cmd.merge) begin
            we    = 1'b1;
            waddr = p_reg;
            wdata = {1'b0, rd_link};
            raddr = rd_link;
        end
        if (cmd.split) begin
            we    = 1'b1;
            waddr = nb;
            wdata = {1'b0, plink_reg};
        end
        if (cmd.mark) begin
            we    = 1'b1;
            waddr = p_reg;
            wdata = {1'b1, nb};
        end
        if (cmd.adv) begin
            raddr = plink_reg;
        end
        if (cmd.free_rd) begin
            raddr = free_idx;
        end
        if (cmd.free_wr) begin
            we    = 1'b1;
            waddr = free_idx;
            wdata = {1'b0, rd_link};
        end
    end

    // write-first: a merge may read the header it rewrites in the same cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb begin
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        need_next       = need_reg;
        p_next          = p_reg;
        plink_next      = plink_reg;
        sp_next         = sp_reg;
        wraps_next      = wraps_reg;
        guard_next      = guard_reg;
        g2_next         = g2_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_status_next   = m_status_reg;
        m_payload_next  = m_payload_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        if (cmd.clr_wr) begin
            clr_next = clr_reg + IDX_W'(1);
        end
        if (cmd.capture) begin
            op_next   = s_op;
            size_next = s_size;
            addr_next = s_addr;
        end
        if (cmd.start) begin
            need_next  = need_calc;
            p_next     = sp_reg;
            wraps_next = '0;
            guard_next = '0;
        end
        if (cmd.chk_p) begin
            plink_next = rd_link;
            g2_next    = '0;
        end
        if (cmd.merge) begin
            plink_next = rd_link;
            g2_next    = g2_reg + G2_W'(1);
        end
        if (cmd.mark) begin
            sp_next         = nb;
            res_status_next = ST_DONE;
            res_addr_next   = pp1_w[ADDR_W-1:0];
        end
        if (cmd.adv) begin
            p_next     = plink_reg;
            wraps_next = wraps_adv;
            guard_next = guard_reg + GUARD_W'(1);
        end
        if (cmd.fail) begin
            sp_next         = TOP;
            res_status_next = ST_NO_SPACE;
            res_addr_next   = '0;
        end
        if (cmd.free_ign) begin
            res_status_next = ST_IGNORED;
            res_addr_next   = '0;
        end
        if (cmd.free_wr) begin
            res_status_next = ST_DONE;
            res_addr_next   = '0;
        end
        if (cmd.out_load) begin
            m_valid_next   = 1'b1;
            m_status_next  = res_status_reg;
            m_payload_next = res_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
            wraps_reg   <= '0;
            guard_reg   <= '0;
            g2_reg      <= '0;
        end else begin
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
            wraps_reg   <= wraps_next;
            guard_reg   <= guard_next;
            g2_reg      <= g2_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        need_reg       <= need_next;
        p_reg          <= p_next;
        plink_reg      <= plink_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_payload_reg  <= m_payload_next;
    end

    assign m_tvalid  = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_payload = m_payload_reg;

endmodule

// ----- rtl/cffa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_ctrl
// Controller: RAM clearing pass, request dispatch, free write-back, chain walk with merging,
// split/mark of the fitting block, and result hand-off.
// ----------------------------------------------------------------------------
module cffa_ctrl
    import cffa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output cmd_t  cmd,
    input  stat_t st
);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_DISPATCH = 10'b0000000100,
        S_CHK_P    = 10'b0000001000,
        S_CHK_Q    = 10'b0000010000,
        S_SPLIT    = 10'b0000100000,
        S_MARK     = 10'b0001000000,
        S_ADV      = 10'b0010000000,
        S_FREE_WR  = 10'b0100000000,
        S_OUT      = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (st.is_free && st.free_bad) begin
                    cmd.free_ign = 1'b1;
                    state_next   = S_OUT;
                end else if (st.is_free) begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_WR;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = S_CHK_P;
                end
            end
            S_CHK_P: begin
                cmd.chk_p = 1'b1;
                if (st.p_busy) begin
                    state_next = S_ADV;
                end else begin
                    state_next = S_CHK_Q;
                end
            end
            S_CHK_Q: begin
                // absorb the next free block until a busy one or the merge limit ends the run
                priority if (!st.q_stop) begin
                    cmd.merge = 1'b1;
                end else if (st.fit && st.split_need) begin
                    state_next = S_SPLIT;
                end else if (st.fit) begin
                    state_next = S_MARK;
                end else begin
                    state_next = S_ADV;
                end
            end
            S_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = S_MARK;
            end
            S_MARK: begin
                cmd.mark   = 1'b1;
                state_next = S_OUT;
            end
            S_ADV: begin
                cmd.adv = 1'b1;
                if (st.adv_stop) begin
                    cmd.fail   = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_CHK_P;
                end
            end
            S_FREE_WR: begin
                cmd.free_wr = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/circular_first_fit_allocator.sv -----
`timescale 1ns / 1ps
// Sequence: a free reads the addressed header and writes it back as free, or is
//   ignored for a bad address; an allocate walks the chain over busy and free
//   headers, merges free runs and splits the fitting block when it is larger.
// Requests: one at a time; the chain walk reads headers through the header RAM's
//   one read port, so allocate time follows fragmentation.
// Reset: after aresetn the header RAM is swept before s_tready first rises;
//   the search pointer restarts at word 0.
// ----------------------------------------------------------------------------
// circular_first_fit_allocator
// Next-fit word allocator over a circular block chain with free-run merging.
// ----------------------------------------------------------------------------
module circular_first_fit_allocator
    import cffa_pkg::*;
#(
    parameter int ARENA_WORDS    = ARENA_WORDS_DEF,
    parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,   // [0] operation
    input  logic [S_TDATA_W-1:0] s_tdata,   // [12:0] size_bytes, [22:13] block_address
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic [M_TDATA_W-1:0] m_tdata    // [9:0] payload_address
);

    cmd_t              cmd;
    stat_t             st;
    logic [ADDR_W-1:0] payload;

    cffa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    cffa_dp #(
        .ARENA_WORDS    (ARENA_WORDS),
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_op      (s_tuser),
        .s_size    (s_tdata[SIZE_W-1:0]),
        .s_addr    (s_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_status  (m_tuser),
        .m_payload (payload)
    );

    assign m_tdata = M_TDATA_W'(payload);

endmodule

// ----- rtl/cffa_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_chk
// Port-level checker for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cffa_chk
    import cffa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [STATUS_W-1:0]  m_tuser,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `CFFA_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    `CFFA_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> (m_tuser == ST_DONE || m_tuser == ST_NO_SPACE || m_tuser == ST_IGNORED), "undefined status code")

    // only a successful allocate carries an address
    `CFFA_ASSERT(a_zero_payload, aclk, aresetn, m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata == '0), "nonzero payload on failed or free beat")

    `CFFA_ASSERT(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

    `CFFA_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid && !s_tready, "ports active right after reset")

endmodule

bind circular_first_fit_allocator cffa_chk u_cffa_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
